// File: rtl/ray_refraction_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef RAY_REFRACTION_UNIT_MACROS_SVH
`define RAY_REFRACTION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RRU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray_refraction_unit port check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define RRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray_refraction_unit port check failed");

`endif

// File: rtl/rru_pkg.sv
`default_nettype none
package rru_pkg;

  localparam int W = 32;
  localparam int F = 16;

  typedef logic signed [W-1:0] word_t;
  typedef logic signed [2*W-1:0] prod_t;

  localparam word_t MAXV = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE  = word_t'(1) <<< F;

  // reciprocal: remainder and quotient of 2^32 / index
  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] quo;
  } div_t;

  // square root: radicand shifter, partial remainder, partial root
  typedef struct packed {
    logic [47:0] x;
    logic [26:0] rem;
    logic [23:0] root;
  } sq_t;

  function automatic prod_t qprod(input word_t a, input word_t b);
    prod_t pa;
    prod_t pb;
    pa = prod_t'(a);
    pb = prod_t'(b);
    return pa * pb;
  endfunction

  // exact product -> truncate toward zero by F bits -> saturate
  function automatic word_t qfin(input prod_t p);
    prod_t adj;
    logic signed [2*W-F-1:0] q;
    adj = p + (p[2*W-1] ? prod_t'((64'sd1 <<< F) - 64'sd1) : prod_t'(0));
    q = $signed(adj[2*W-1:F]);
    if (q > (2*W-F)'(MAXV)) return MAXV;
    if (q < (2*W-F)'(MINV)) return MINV;
    return q[W-1:0];
  endfunction

  function automatic word_t sat33(input logic signed [W:0] s);
    if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
    return s[W-1:0];
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return sat33({a[W-1], a} + {b[W-1], b});
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    return sat33({a[W-1], a} - {b[W-1], b});
  endfunction

  function automatic word_t sat_neg(input word_t v);
    return (v == MINV) ? MAXV : -v;
  endfunction

  // four restoring division steps
  function automatic div_t div_step4(input div_t s, input logic [30:0] idx);
    div_t o;
    logic [31:0] r2;
    o = s;
    for (int i = 0; i < 4; i++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, idx}) begin
        r2 = r2 - {1'b0, idx};
        o.quo = {o.quo[30:0], 1'b1};
      end else begin
        o.quo = {o.quo[30:0], 1'b0};
      end
      o.rem = r2[30:0];
    end
    return o;
  endfunction

  // four restoring square-root steps (two radicand bits each)
  function automatic sq_t sqrt_step4(input sq_t s);
    sq_t o;
    logic [26:0] r;
    logic [26:0] trial;
    o = s;
    for (int i = 0; i < 4; i++) begin
      r = {o.rem[24:0], o.x[47:46]};
      o.x = {o.x[45:0], 2'b00};
      trial = {1'b0, o.root, 2'b01};
      if (r >= trial) begin
        r = r - trial;
        o.root = {o.root[22:0], 1'b1};
      end else begin
        o.root = {o.root[22:0], 1'b0};
      end
      o.rem = r;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ray_refraction_unit.sv
`default_nettype none
// Snell refraction pipeline. One ray per transfer on s_axis, one result per
// ray on m_axis, in order. A new ray may enter every cycle while the pipe
// is not held. Dot product and, in parallel, reciprocal (eight stages of
// four quotient bits) -> eta^2*(1-c^2) -> square root (six stages of four
// root bits) -> direction -> origin. All stages advance together and hold
// when the output register is full and m_axis_tready is low. m_axis_tuser
// is 1 for a refracted ray and 0 for total internal reflection, in which
// case all data fields are zero. Values are signed Q16.16 with saturation
// on every product and sum. offset_epsilon (reset 66) is written through
// cfg_we/cfg_data and must only change while the pipeline is empty.
module ray_refraction_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, hit_x, hit_y, hit_z,
  // material_index[30:0], generation_in[15:0], one pad bit
  input  wire logic [335:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // origin_x, origin_y, origin_z, new_dir_x, new_dir_y, new_dir_z,
  // generation_out[15:0]
  output logic [207:0]      m_axis_tdata,
  // refracted_valid
  output logic [0:0]        m_axis_tuser
);

  localparam int NST = 24;

  // stage map
  localparam int S_IN   = 0;   // input register
  localparam int S_DOTP = 1;   // n.d and -n.d products
  localparam int S_DOT  = 2;   // dot sums
  localparam int S_SEL  = 3;   // pick side
  localparam int S_DIV0 = 1;   // reciprocal steps S_DIV0..S_DIV1
  localparam int S_DIV1 = 8;
  localparam int S_ETA  = 9;   // eta select, eta*eta, c*eta, c*c, d*eta
  localparam int S_FIN  = 10;
  localparam int S_DP   = 11;  // eta^2 * t
  localparam int S_DISC = 12;
  localparam int S_SQ0  = 13;  // square root steps S_SQ0..S_SQ1
  localparam int S_SQ1  = 18;
  localparam int S_B    = 19;
  localparam int S_NBP  = 20;
  localparam int S_ND   = 21;
  localparam int S_EPP  = 22;
  localparam int S_OUT  = 23;

  typedef struct packed {
    rru_pkg::word_t [2:0] d;
    rru_pkg::word_t [2:0] n;
    rru_pkg::word_t [2:0] nn;
    rru_pkg::word_t [2:0] h;
    logic [30:0]          idx;
    logic [15:0]          gen;
    rru_pkg::prod_t [5:0] p;
    rru_pkg::word_t       c0;
    rru_pkg::word_t       c1;
    logic                 flip;
    rru_pkg::div_t        dv;
    rru_pkg::word_t       ee;
    rru_pkg::word_t       ce;
    rru_pkg::word_t       t;
    rru_pkg::word_t [2:0] deta;
    logic                 tir;
    rru_pkg::sq_t         sq;
    rru_pkg::word_t       b;
    rru_pkg::word_t [2:0] nd;
    rru_pkg::word_t [2:0] org;
  } stage_t;

  stage_t         st [NST];
  stage_t         nx [NST];
  logic [NST-1:0] vld;
  logic [15:0]    eps;
  logic           en;

  rru_pkg::word_t eta;
  rru_pkg::word_t cs;
  rru_pkg::word_t disc;

  // whole pipe moves unless the output holds an untaken result
  assign en            = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    eta  = '0;
    cs   = '0;
    disc = '0;

    nx[S_IN] = '0;
    for (int i = 0; i < 3; i++) begin
      nx[S_IN].d[i] = s_axis_tdata[32*i +: 32];
      nx[S_IN].n[i] = s_axis_tdata[96 + 32*i +: 32];
      nx[S_IN].h[i] = s_axis_tdata[192 + 32*i +: 32];
      nx[S_IN].nn[i] = rru_pkg::sat_neg(s_axis_tdata[96 + 32*i +: 32]);
    end
    nx[S_IN].idx    = s_axis_tdata[318:288];
    nx[S_IN].gen    = s_axis_tdata[334:319];
    nx[S_IN].dv.rem = 31'd1;   // first dividend bit already brought down
    nx[S_IN].dv.quo = '0;

    for (int k = 1; k < NST; k++) nx[k] = st[k-1];

    for (int i = 0; i < 3; i++) begin
      nx[S_DOTP].p[i]   = rru_pkg::qprod(st[S_DOTP-1].n[i], st[S_DOTP-1].d[i]);
      nx[S_DOTP].p[3+i] = rru_pkg::qprod(st[S_DOTP-1].nn[i], st[S_DOTP-1].d[i]);
    end

    nx[S_DOT].c0 = rru_pkg::sat_add(rru_pkg::sat_add(rru_pkg::qfin(st[S_DOT-1].p[0]),
                     rru_pkg::qfin(st[S_DOT-1].p[1])), rru_pkg::qfin(st[S_DOT-1].p[2]));
    nx[S_DOT].c1 = rru_pkg::sat_add(rru_pkg::sat_add(rru_pkg::qfin(st[S_DOT-1].p[3]),
                     rru_pkg::qfin(st[S_DOT-1].p[4])), rru_pkg::qfin(st[S_DOT-1].p[5]));

    // ray leaving the material: flip the normal once, use the index itself
    nx[S_SEL].flip = ($signed(st[S_SEL-1].c0) > 0);
    if (nx[S_SEL].flip) begin
      nx[S_SEL].c0 = st[S_SEL-1].c1;
      nx[S_SEL].n  = st[S_SEL-1].nn;
    end

    for (int k = S_DIV0; k <= S_DIV1; k++)
      nx[k].dv = rru_pkg::div_step4(nx[k].dv, nx[k].idx);

    // index of two or less gives a reciprocal past the word range
    if (st[S_ETA-1].flip)
      eta = rru_pkg::word_t'({1'b0, st[S_ETA-1].idx});
    else if (st[S_ETA-1].idx <= 31'd2)
      eta = rru_pkg::MAXV;
    else
      eta = st[S_ETA-1].dv.quo;
    cs = st[S_ETA-1].c0;
    nx[S_ETA].p[0] = rru_pkg::qprod(eta, eta);
    nx[S_ETA].p[1] = rru_pkg::qprod(cs, eta);
    nx[S_ETA].p[2] = rru_pkg::qprod(cs, cs);
    for (int i = 0; i < 3; i++)
      nx[S_ETA].p[3+i] = rru_pkg::qprod(st[S_ETA-1].d[i], eta);

    nx[S_FIN].ee = rru_pkg::qfin(st[S_FIN-1].p[0]);
    nx[S_FIN].ce = rru_pkg::qfin(st[S_FIN-1].p[1]);
    nx[S_FIN].t  = rru_pkg::sat_sub(rru_pkg::ONE, rru_pkg::qfin(st[S_FIN-1].p[2]));
    for (int i = 0; i < 3; i++)
      nx[S_FIN].deta[i] = rru_pkg::qfin(st[S_FIN-1].p[3+i]);

    nx[S_DP].p[0] = rru_pkg::qprod(st[S_DP-1].ee, st[S_DP-1].t);

    disc = rru_pkg::sat_sub(rru_pkg::ONE, rru_pkg::qfin(st[S_DISC-1].p[0]));
    nx[S_DISC].tir     = disc[31];
    nx[S_DISC].sq.x    = {disc, 16'd0};
    nx[S_DISC].sq.rem  = '0;
    nx[S_DISC].sq.root = '0;

    for (int k = S_SQ0; k <= S_SQ1; k++)
      nx[k].sq = rru_pkg::sqrt_step4(nx[k].sq);

    nx[S_B].b = rru_pkg::sat_add(st[S_B-1].ce, rru_pkg::word_t'({8'd0, st[S_B-1].sq.root}));

    for (int i = 0; i < 3; i++)
      nx[S_NBP].p[i] = rru_pkg::qprod(st[S_NBP-1].n[i], st[S_NBP-1].b);

    for (int i = 0; i < 3; i++)
      nx[S_ND].nd[i] = rru_pkg::sat_sub(st[S_ND-1].deta[i], rru_pkg::qfin(st[S_ND-1].p[i]));

    for (int i = 0; i < 3; i++)
      nx[S_EPP].p[i] = rru_pkg::qprod(st[S_EPP-1].nd[i], rru_pkg::word_t'({16'd0, eps}));

    // final stage: origin, generation, zeroing on total internal reflection
    for (int i = 0; i < 3; i++)
      nx[S_OUT].org[i] = rru_pkg::sat_add(st[S_OUT-1].h[i], rru_pkg::qfin(st[S_OUT-1].p[i]));
    if (st[S_OUT-1].tir) begin
      nx[S_OUT].org = '0;
      nx[S_OUT].nd  = '0;
      nx[S_OUT].gen = '0;
    end else if (st[S_OUT-1].gen != 16'hFFFF) begin
      nx[S_OUT].gen = st[S_OUT-1].gen + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) st[k] <= nx[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 16'd66;
    end else if (cfg_we) begin
      eps <= cfg_data;
    end
  end

  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tuser  = ~st[S_OUT].tir;
  assign m_axis_tdata  = {st[S_OUT].gen,
                          st[S_OUT].nd[2], st[S_OUT].nd[1], st[S_OUT].nd[0],
                          st[S_OUT].org[2], st[S_OUT].org[1], st[S_OUT].org[0]};

endmodule
`default_nettype wire

// File: rtl/ray_refraction_unit_chk.sv
`default_nettype none
`include "ray_refraction_unit_macros.svh"
module ray_refraction_unit_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [207:0] m_axis_tdata,
  input wire logic [0:0]   m_axis_tuser
);

  `RRU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `RRU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `RRU_ASSERT_NOW(a_tir_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
  `RRU_ASSERT_NOW(a_gen_nonzero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[207:192] != 16'd0)
  `RRU_ASSERT_NOW(a_ready_free, !m_axis_tvalid, s_axis_tready)

endmodule

bind ray_refraction_unit ray_refraction_unit_chk u_chk (.*);
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd65536;
  localparam int PIPE_DEPTH = 24;

  typedef struct {
    longint dir[3];
    longint nrm[3];
    longint hit[3];
    longint idx;
    int unsigned gen;
  } ray_t;

  typedef struct {
    bit ok;
    longint org[3];
    longint ndir[3];
    int unsigned gen;
  } refr_t;

  // Fixed-point refraction predictor plus queue of pending expected results
  class refr_scoreboard;
    refr_t pending[$];
    int errors;
    longint eps;

    function new();
      errors = 0;
      eps = 66;
    endfunction

    function longint clampw(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = m >>> 16;
      return clampw((p < 0) ? -m : m);
    endfunction

    function longint qsqrt(longint d);
      longint x;
      longint r;
      longint t;
      x = d <<< 16;
      r = 0;
      for (int b = 23; b >= 0; b--) begin
        t = r | (64'sd1 <<< b);
        if (t * t <= x) r = t;
      end
      return clampw(r);
    endfunction

    function longint dot3(longint a[3], longint b[3]);
      return clampw(clampw(qmul(a[0], b[0]) + qmul(a[1], b[1])) + qmul(a[2], b[2]));
    endfunction

    function void note_ray(ray_t r);
      refr_t e;
      longint n[3];
      longint c;
      longint eta;
      longint t;
      longint disc;
      longint bterm;
      n = r.nrm;
      e.ok = 0;
      e.gen = 0;
      for (int i = 0; i < 3; i++) begin
        e.org[i] = 0;
        e.ndir[i] = 0;
      end
      c = dot3(n, r.dir);
      if (c > 0) begin
        // leaving the material: flip normal once, eta is the index itself
        for (int i = 0; i < 3; i++) n[i] = clampw(-n[i]);
        c = dot3(n, r.dir);
        eta = clampw(r.idx);
      end else if (r.idx == 0) begin
        eta = QMAX;
      end else begin
        eta = clampw((64'sd1 <<< 32) / r.idx);
      end
      t = clampw(QONE - qmul(c, c));
      disc = clampw(QONE - qmul(qmul(eta, eta), t));
      if (disc >= 0) begin
        bterm = clampw(qmul(c, eta) + qsqrt(disc));
        for (int i = 0; i < 3; i++) begin
          e.ndir[i] = clampw(qmul(r.dir[i], eta) - qmul(n[i], bterm));
          e.org[i] = clampw(r.hit[i] + qmul(e.ndir[i], eps));
        end
        e.ok = 1;
        e.gen = (r.gen >= 65535) ? 65535 : r.gen + 1;
      end
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_result(logic [207:0] data, logic [0:0] user);
      refr_t e;
      longint g;
      if (pending.size() == 0) begin
        report("pending results", 0, 1);
        return;
      end
      e = pending.pop_front();
      if (user[0] !== e.ok) report("refracted_valid", user[0], e.ok);
      for (int i = 0; i < 3; i++) begin
        g = longint'($signed(data[32*i +: 32]));
        if (g != e.org[i]) report($sformatf("origin[%0d]", i), g, e.org[i]);
        g = longint'($signed(data[96 + 32*i +: 32]));
        if (g != e.ndir[i]) report($sformatf("new_dir[%0d]", i), g, e.ndir[i]);
      end
      if (data[207:192] != e.gen) report("generation_out", data[207:192], e.gen);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [335:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [207:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  refr_scoreboard sb = new();
  bit calm = 0;  // no idling on either side near the end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ray_refraction_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // result side: check every accepted transfer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver back-pressure in random bursts
  initial begin
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        @(posedge clk) m_axis_tready <= 0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end
      @(posedge clk) m_axis_tready <= 1;
      repeat ($urandom_range(0, 19)) @(posedge clk);
    end
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_ray(ray_t r);
    logic [335:0] d;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[32*i +: 32] = r.dir[i][31:0];
      d[96 + 32*i +: 32] = r.nrm[i][31:0];
      d[192 + 32*i +: 32] = r.hit[i][31:0];
    end
    d[318:288] = r.idx[30:0];
    d[334:319] = r.gen[15:0];
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_ray(r);
  endtask

  task automatic set_epsilon(logic [15:0] v);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 6) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.eps = v;
  endtask

  function automatic longint rnd_word();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint rnd_unitish();
    return longint'($urandom_range(0, 131072)) - 65536;
  endfunction

  function automatic ray_t rnd_ray();
    ray_t r;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      r.dir[i] = (kind < 7) ? rnd_unitish() : rnd_word();
      r.nrm[i] = (kind < 7) ? rnd_unitish() : rnd_word();
      r.hit[i] = rnd_word();
    end
    // mostly plausible indices, sometimes any 31-bit value
    r.idx = (kind < 8) ? longint'($urandom_range(65536, 196608))
                       : longint'($urandom() & 32'h7fff_ffff);
    r.gen = ($urandom_range(0, 9) == 0) ? 65535 - $urandom_range(0, 1) : $urandom() & 16'hffff;
    return r;
  endfunction

  function automatic ray_t mk(longint dx, longint dy, longint dz, longint nx, longint ny,
                              longint nz, longint idx, int unsigned gen);
    ray_t r;
    r.dir = '{dx, dy, dz};
    r.nrm = '{nx, ny, nz};
    r.hit = '{rnd_word(), rnd_word(), rnd_word()};
    r.idx = idx;
    r.gen = gen;
    return r;
  endfunction

  initial begin
    ray_t r;
    logic [15:0] eps_set[4];
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: entering head on, grazing, exiting, total reflection, extremes
    send_ray(mk(0, 0, -65536, 0, 0, 65536, 98304, 0));
    send_ray(mk(46341, 0, -46341, 0, 0, 65536, 98304, 3));
    send_ray(mk(0, 0, 65536, 0, 0, 65536, 98304, 7));        // exiting, flip
    send_ray(mk(60000, 0, 26000, 0, 0, 65536, 98304, 9));    // exiting steep: TIR
    send_ray(mk(65536, 0, 0, 0, 0, 65536, 65536, 1));        // exact grazing
    send_ray(mk(0, -65536, 0, 0, 65536, 0, 0, 2));           // zero index
    send_ray(mk(0, -65536, 0, 0, 65536, 0, QMAX, 5));        // widest index
    send_ray(mk(0, 65536, 0, 0, 65536, 0, QMAX, 5));         // exit, huge eta
    send_ray(mk(0, 0, -65536, 0, 0, 65536, 1, 4));           // tiny index
    send_ray(mk(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 65536, 11)); // flip saturates
    send_ray(mk(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, 98304, 12));
    send_ray(mk(QMAX, QMIN, 0, QMAX, QMIN, 0, 65536, 13));
    send_ray(mk(0, 0, 0, 0, 0, 0, 65536, 65535));            // generation max
    send_ray(mk(0, 0, -65536, 0, 0, 65536, 98304, 65534));
    r = mk(0, 0, -65536, 0, 0, 65536, 98304, 6);
    r.hit = '{QMAX, QMIN, QMAX};
    send_ray(r);
    r.hit = '{QMIN, QMAX, -1};
    r.dir = '{0, 0, 65536};
    send_ray(r);
    send_ray(mk(-1, -1, -1, 1, 1, 1, 32'h7fff_ffff, 0));

    eps_set = '{16'd0, 16'hffff, 16'd1, 16'($urandom())};
    for (int ph = 0; ph < 4; ph++) begin
      set_epsilon(eps_set[ph]);
      if (ph == 1) begin
        r = mk(0, 0, -65536, 0, 0, 65536, 98304, 1);
        r.hit = '{QMAX, QMIN, 0};
        send_ray(r);
      end
      for (int k = 0; k < 100; k++) begin
        if (ph == 3 && k >= 70) calm = 1;
        send_ray(rnd_ray());
      end
    end
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/rru_pkg.sv
rtl/ray_refraction_unit.sv
rtl/ray_refraction_unit_chk.sv
test/testbench.sv
